@@ rtl/tqs_pkg.sv @@
// Shared types and constants for the textured quad split block.
// No dependencies; used by every module of the block.
package tqs_pkg;

	localparam int COORD_W = 24;
	localparam int KIND_W = 4;
	localparam int QUOT_W = COORD_W;
	localparam int REM_W = COORD_W + 1;
	localparam int PROD_W = REM_W + QUOT_W;
	localparam int DIV_STEP = 3;
	localparam int DIV_STAGES = QUOT_W / DIV_STEP;

	localparam logic CMD_VERT = 1'b0;
	localparam logic CMD_HORIZ = 1'b1;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic command;
		coord_t split_pos;
		coord_t edge_left;
		coord_t edge_top;
		coord_t edge_right;
		coord_t edge_bottom;
		coord_t tex_left;
		coord_t tex_right;
		coord_t tex_top;
		coord_t tex_bottom;
		logic [KIND_W-1:0] quad_kind;
	} quad_in_t;

	typedef struct packed {
		coord_t out_left;
		coord_t out_top;
		coord_t out_right;
		coord_t out_bottom;
		coord_t out_tex_left;
		coord_t out_tex_right;
		coord_t out_tex_top;
		coord_t out_tex_bottom;
		logic [KIND_W-1:0] out_kind;
		logic last_piece;
	} quad_out_t;

	typedef struct packed {
		quad_in_t quad;
		logic whole;
		logic neg;
	} side_t;

endpackage

@@ rtl/tqs_div.sv @@
// Pipelined unsigned restoring divider, DIV_STEP quotient bits per stage.
// Depends on tqs_pkg for widths.
module tqs_div (
	input logic clk,
	input logic [tqs_pkg::REM_W-1:0] rem_in,
	input logic [tqs_pkg::QUOT_W-1:0] low_in,
	input logic [tqs_pkg::COORD_W-1:0] den_in,
	output logic [tqs_pkg::QUOT_W-1:0] quot
);

	logic [tqs_pkg::REM_W-1:0] rem_st [tqs_pkg::DIV_STAGES+1];
	logic [tqs_pkg::QUOT_W-1:0] n_st [tqs_pkg::DIV_STAGES+1];
	logic [tqs_pkg::COORD_W-1:0] d_st [tqs_pkg::DIV_STAGES+1];

	assign rem_st[0] = rem_in;
	assign n_st[0] = low_in;
	assign d_st[0] = den_in;

	for (genvar s = 0; s < tqs_pkg::DIV_STAGES; s++) begin : g_stage
		logic [tqs_pkg::REM_W-1:0] r_c;
		logic [tqs_pkg::QUOT_W-1:0] n_c;
		always_comb begin
			logic [tqs_pkg::REM_W:0] t;
			logic ge;
			r_c = rem_st[s];
			n_c = n_st[s];
			for (int k = 0; k < tqs_pkg::DIV_STEP; k++) begin
				t = {r_c, n_c[tqs_pkg::QUOT_W-1]};
				ge = t >= {2'b00, d_st[s]};
				if (ge) begin
					t = t - {2'b00, d_st[s]};
				end
				r_c = t[tqs_pkg::REM_W-1:0];
				n_c = {n_c[tqs_pkg::QUOT_W-2:0], ge};
			end
		end
		always_ff @(posedge clk) begin
			rem_st[s+1] <= r_c;
			n_st[s+1] <= n_c;
			d_st[s+1] <= d_st[s];
		end
	end

	assign quot = n_st[tqs_pkg::DIV_STAGES];

endmodule

@@ rtl/textured_quad_axis_split.sv @@
// Throughput: one quad per cycle when it passes whole, while busy is low; busy rises
// for the cycle after a split quad is taken, set by the single result port.
// Reset clears valid bits, busy and strobe; no state survives between quads.
// Depends on tqs_pkg and tqs_div.
module textured_quad_axis_split (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input tqs_pkg::quad_in_t quad,
	output logic strobe,
	output tqs_pkg::quad_out_t result
);

	localparam int NS = tqs_pkg::DIV_STAGES;

	logic acc;
	logic whole_in;
	logic busy_q;

	always_comb begin
		if (quad.command == tqs_pkg::CMD_VERT) begin
			whole_in = (quad.edge_right <= quad.split_pos) || (quad.edge_left >= quad.split_pos);
		end else begin
			whole_in = (quad.edge_bottom <= quad.split_pos) || (quad.edge_top >= quad.split_pos);
		end
	end

	assign busy = busy_q;
	assign acc = start && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else begin
			busy_q <= acc && !whole_in;
		end
	end

	logic v_s1;
	tqs_pkg::quad_in_t q_s1;
	logic whole_s1;

	always_ff @(posedge clk) begin
		q_s1 <= quad;
		whole_s1 <= whole_in;
	end

	logic [tqs_pkg::COORD_W-1:0] pd_w, den_w;
	logic [tqs_pkg::REM_W-1:0] mag_w;
	logic neg_w;
	always_comb begin
		logic signed [tqs_pkg::REM_W-1:0] pd, td, dn;
		tqs_pkg::coord_t e_near, e_far, t_near, t_far;
		if (q_s1.command == tqs_pkg::CMD_VERT) begin
			e_near = q_s1.edge_left;
			e_far = q_s1.edge_right;
			t_near = q_s1.tex_left;
			t_far = q_s1.tex_right;
		end else begin
			e_near = q_s1.edge_top;
			e_far = q_s1.edge_bottom;
			t_near = q_s1.tex_top;
			t_far = q_s1.tex_bottom;
		end
		pd = {q_s1.split_pos[tqs_pkg::COORD_W-1], q_s1.split_pos} - {e_near[tqs_pkg::COORD_W-1], e_near};
		dn = {e_far[tqs_pkg::COORD_W-1], e_far} - {e_near[tqs_pkg::COORD_W-1], e_near};
		td = {t_far[tqs_pkg::COORD_W-1], t_far} - {t_near[tqs_pkg::COORD_W-1], t_near};
		neg_w = td[tqs_pkg::REM_W-1];
		mag_w = neg_w ? tqs_pkg::REM_W'(-td) : tqs_pkg::REM_W'(td);
		pd_w = pd[tqs_pkg::COORD_W-1:0];
		den_w = dn[tqs_pkg::COORD_W-1:0];
	end

	logic v_s2;
	tqs_pkg::side_t side_s2;
	logic [tqs_pkg::PROD_W-1:0] prod_s2;
	logic [tqs_pkg::COORD_W-1:0] den_s2;

	always_ff @(posedge clk) begin
		side_s2 <= '{quad: q_s1, whole: whole_s1, neg: neg_w};
		prod_s2 <= tqs_pkg::PROD_W'(pd_w) * tqs_pkg::PROD_W'(mag_w);
		den_s2 <= den_w;
	end

	logic [tqs_pkg::QUOT_W-1:0] quot;

	tqs_div u_div (
		.clk(clk),
		.rem_in(prod_s2[tqs_pkg::PROD_W-1:tqs_pkg::QUOT_W]),
		.low_in(prod_s2[tqs_pkg::QUOT_W-1:0]),
		.den_in(den_s2),
		.quot(quot)
	);

	tqs_pkg::side_t side_d [NS];
	logic [NS-1:0] v_d;

	always_ff @(posedge clk) begin
		side_d[0] <= side_s2;
		for (int i = 1; i < NS; i++) begin
			side_d[i] <= side_d[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_d <= '0;
		end else begin
			v_s1 <= acc;
			v_s2 <= v_s1;
			v_d <= {v_d[NS-2:0], v_s2};
		end
	end

	tqs_pkg::side_t sf;
	tqs_pkg::quad_out_t whole_o, a_o, b_o;
	assign sf = side_d[NS-1];

	always_comb begin
		tqs_pkg::coord_t sq, t, t_near;
		sq = sf.neg ? tqs_pkg::coord_t'(-quot) : tqs_pkg::coord_t'(quot);
		t_near = (sf.quad.command == tqs_pkg::CMD_VERT) ? sf.quad.tex_left : sf.quad.tex_top;
		t = t_near + sq;
		whole_o.out_left = sf.quad.edge_left;
		whole_o.out_top = sf.quad.edge_top;
		whole_o.out_right = sf.quad.edge_right;
		whole_o.out_bottom = sf.quad.edge_bottom;
		whole_o.out_tex_left = sf.quad.tex_left;
		whole_o.out_tex_right = sf.quad.tex_right;
		whole_o.out_tex_top = sf.quad.tex_top;
		whole_o.out_tex_bottom = sf.quad.tex_bottom;
		whole_o.out_kind = sf.quad.quad_kind;
		whole_o.last_piece = 1'b1;
		a_o = whole_o;
		b_o = whole_o;
		a_o.last_piece = 1'b0;
		if (sf.quad.command == tqs_pkg::CMD_VERT) begin
			a_o.out_right = sf.quad.split_pos;
			a_o.out_tex_right = t;
			b_o.out_left = sf.quad.split_pos;
			b_o.out_tex_left = t;
		end else begin
			a_o.out_bottom = sf.quad.split_pos;
			a_o.out_tex_bottom = t;
			b_o.out_top = sf.quad.split_pos;
			b_o.out_tex_top = t;
		end
	end

	logic pend_q;
	logic strobe_q;
	tqs_pkg::quad_out_t res_q, b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= pend_q || v_d[NS-1];
			pend_q <= !pend_q && v_d[NS-1] && !sf.whole;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_q) begin
			res_q <= b_q;
		end else if (sf.whole) begin
			res_q <= whole_o;
		end else begin
			res_q <= a_o;
		end
		b_q <= b_o;
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule

@@ tb/tb_textured_quad_axis_split.sv @@
// Testbench for textured_quad_axis_split: directed and random quads, split and whole.
// Predicts each piece in a scoreboard class and checks every strobed result in order.
// Depends on tqs_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_textured_quad_axis_split;
	import tqs_pkg::*;

	class piece_board;
		quad_out_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function coord_t cut_tex(coord_t pos, coord_t en, coord_t ef, coord_t tn, coord_t tf);
			longint num, den;
			num = (longint'(pos) - longint'(en)) * (longint'(tf) - longint'(tn));
			den = longint'(ef) - longint'(en);
			return coord_t'(longint'(tn) + num / den);
		endfunction

		function void note_quad(quad_in_t q);
			quad_out_t a, b;
			coord_t t;
			a.out_left = q.edge_left;
			a.out_top = q.edge_top;
			a.out_right = q.edge_right;
			a.out_bottom = q.edge_bottom;
			a.out_tex_left = q.tex_left;
			a.out_tex_right = q.tex_right;
			a.out_tex_top = q.tex_top;
			a.out_tex_bottom = q.tex_bottom;
			a.out_kind = q.quad_kind;
			a.last_piece = 1'b1;
			b = a;
			if (q.command == CMD_VERT) begin
				if (q.edge_right <= q.split_pos || q.edge_left >= q.split_pos) begin
					pending.push_back(a);
					return;
				end
				t = cut_tex(q.split_pos, q.edge_left, q.edge_right, q.tex_left, q.tex_right);
				a.out_right = q.split_pos;
				a.out_tex_right = t;
				b.out_left = q.split_pos;
				b.out_tex_left = t;
			end else begin
				if (q.edge_bottom <= q.split_pos || q.edge_top >= q.split_pos) begin
					pending.push_back(a);
					return;
				end
				t = cut_tex(q.split_pos, q.edge_top, q.edge_bottom, q.tex_top, q.tex_bottom);
				a.out_bottom = q.split_pos;
				a.out_tex_bottom = t;
				b.out_top = q.split_pos;
				b.out_tex_top = t;
			end
			a.last_piece = 1'b0;
			pending.push_back(a);
			pending.push_back(b);
		endfunction

		function void check_piece(quad_out_t r);
			quad_out_t e;
			if (pending.size() == 0) begin
				$error("unexpected result %p", r);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (r.out_left !== e.out_left) begin
				$error("out_left exp %0d got %0d", e.out_left, r.out_left); errors++;
			end
			if (r.out_top !== e.out_top) begin
				$error("out_top exp %0d got %0d", e.out_top, r.out_top); errors++;
			end
			if (r.out_right !== e.out_right) begin
				$error("out_right exp %0d got %0d", e.out_right, r.out_right); errors++;
			end
			if (r.out_bottom !== e.out_bottom) begin
				$error("out_bottom exp %0d got %0d", e.out_bottom, r.out_bottom); errors++;
			end
			if (r.out_tex_left !== e.out_tex_left) begin
				$error("out_tex_left exp %0d got %0d", e.out_tex_left, r.out_tex_left);
				errors++;
			end
			if (r.out_tex_right !== e.out_tex_right) begin
				$error("out_tex_right exp %0d got %0d", e.out_tex_right, r.out_tex_right);
				errors++;
			end
			if (r.out_tex_top !== e.out_tex_top) begin
				$error("out_tex_top exp %0d got %0d", e.out_tex_top, r.out_tex_top); errors++;
			end
			if (r.out_tex_bottom !== e.out_tex_bottom) begin
				$error("out_tex_bottom exp %0d got %0d", e.out_tex_bottom, r.out_tex_bottom);
				errors++;
			end
			if (r.out_kind !== e.out_kind) begin
				$error("out_kind exp %0d got %0d", e.out_kind, r.out_kind); errors++;
			end
			if (r.last_piece !== e.last_piece) begin
				$error("last_piece exp %0d got %0d", e.last_piece, r.last_piece); errors++;
			end
		endfunction
	endclass

	localparam coord_t CMAX = 24'sh7fffff;
	localparam coord_t CMIN = -24'sh800000;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	quad_in_t quad = '0;
	logic strobe;
	quad_out_t result;
	piece_board board = new();
	int cycles = 0;

	textured_quad_axis_split dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.quad(quad), .strobe(strobe), .result(result)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && strobe)
			board.check_piece(result);
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_quad(quad_in_t q, int gap);
		repeat (gap) @(negedge clk);
		quad = q;
		start = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note_quad(q);
		@(negedge clk);
		start = 1'b0;
	endtask

	function automatic coord_t rnd_coord();
		case ($urandom_range(0, 5))
			0: return CMAX;
			1: return CMIN;
			2: return coord_t'($urandom_range(0, 4095)) - 24'sd2048;
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic quad_in_t make_quad(logic cmd, coord_t lo_x, coord_t hi_x,
		coord_t lo_y, coord_t hi_y, coord_t pos);
		quad_in_t q;
		q.command = cmd;
		q.split_pos = pos;
		q.edge_left = lo_x;
		q.edge_right = hi_x;
		q.edge_top = lo_y;
		q.edge_bottom = hi_y;
		q.tex_left = rnd_coord();
		q.tex_right = rnd_coord();
		q.tex_top = rnd_coord();
		q.tex_bottom = rnd_coord();
		q.quad_kind = 4'($urandom);
		return q;
	endfunction

	function automatic quad_in_t random_quad();
		quad_in_t q;
		coord_t a, b, c;
		logic cmd;
		longint lo, hi;
		cmd = logic'($urandom_range(0, 1));
		a = rnd_coord();
		b = rnd_coord();
		if (a > b) begin
			c = a; a = b; b = c;
		end
		if ($urandom_range(0, 9) == 0) begin
			c = a; a = b; b = c;
		end
		lo = a;
		hi = b;
		if ($urandom_range(0, 9) < 7 && hi - lo > 1)
			c = coord_t'(lo + 1 + longint'($urandom) % (hi - lo - 1));
		else
			case ($urandom_range(0, 3))
				0: c = a;
				1: c = b;
				default: c = rnd_coord();
			endcase
		if (cmd == CMD_VERT)
			q = make_quad(cmd, a, b, rnd_coord(), rnd_coord(), c);
		else
			q = make_quad(cmd, rnd_coord(), rnd_coord(), a, b, c);
		return q;
	endfunction

	initial begin
		quad_in_t q;
		int gap;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_quad(make_quad(CMD_VERT, CMIN, CMAX, CMIN, CMAX, 24'sd0), 0);
		send_quad(make_quad(CMD_HORIZ, CMIN, CMAX, CMIN, CMAX, 24'sd0), 0);
		send_quad(make_quad(CMD_VERT, CMIN, CMAX, 0, 256, CMAX - 24'sd1), 0);
		send_quad(make_quad(CMD_VERT, CMIN, CMAX, 0, 256, CMIN + 24'sd1), 1);
		send_quad(make_quad(CMD_HORIZ, 0, 256, CMIN, CMAX, CMAX - 24'sd1), 0);
		send_quad(make_quad(CMD_HORIZ, 0, 256, CMIN, CMAX, CMIN + 24'sd1), 0);
		send_quad(make_quad(CMD_VERT, 0, 256, 0, 256, 24'sd256), 0);
		send_quad(make_quad(CMD_VERT, 0, 256, 0, 256, 24'sd0), 0);
		send_quad(make_quad(CMD_HORIZ, 0, 256, 0, 256, 24'sd256), 2);
		send_quad(make_quad(CMD_HORIZ, 0, 256, 0, 256, 24'sd0), 0);
		send_quad(make_quad(CMD_VERT, 256, 0, 0, 256, 24'sd128), 0);
		send_quad(make_quad(CMD_HORIZ, 0, 256, 256, 0, 24'sd128), 0);
		send_quad(make_quad(CMD_VERT, 10, 10, 0, 256, 24'sd10), 0);
		send_quad(make_quad(CMD_VERT, 0, 2, 0, 256, 24'sd1), 0);
		send_quad(make_quad(CMD_HORIZ, 0, 256, CMIN, CMAX, CMIN), 0);
		send_quad(make_quad(CMD_VERT, 0, 3, 0, 1, 24'sd500), 3);
		q = make_quad(CMD_VERT, -300, 700, 0, 5, -7);
		q.tex_left = CMAX; q.tex_right = CMIN; q.quad_kind = 4'hf;
		send_quad(q, 0);
		q = make_quad(CMD_HORIZ, 0, 5, -300, 700, 11);
		q.tex_top = CMIN; q.tex_bottom = CMAX; q.quad_kind = 4'h0;
		send_quad(q, 0);

		for (int i = 0; i < 1600; i++) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			if (i % 400 < 60)
				gap = 0;
			if (i == 800) begin
				while (board.pending.size() != 0) @(negedge clk);
				repeat (20) @(negedge clk);
			end
			send_quad(random_quad(), gap);
		end

		while (board.pending.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		if (board.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
